FILE: rtl/core/srr_pkg.sv
// Shared constants, types and codes of the stereo polyphase resampler.
// Used by srr_ctrl, srr_dp and stereo_polyphase_resampler_top; depends on nothing.
package srr_pkg;

  localparam int MAX_TAPS        = 64;
  localparam int MAX_LOG2_PHASES = 5;
  localparam int BLEND_BITS      = 6;
  localparam int COEF_DEPTH      = ((2 ** MAX_LOG2_PHASES) + 1) * MAX_TAPS;
  localparam int COEF_AW         = 12;
  localparam int HIST_AW         = 6;
  localparam int RESULT_CAP      = 64;
  localparam int ACC_W           = 41;
  localparam int CFG_W           = 39;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_STEP_RATIO  = 3'd0,
    CFG_START_POS   = 3'd1,
    CFG_DITHER_SEED = 3'd2,
    CFG_LCG_MUL     = 3'd3,
    CFG_LCG_ADD     = 3'd4,
    CFG_TAPS        = 3'd5,
    CFG_LOG2_PHASES = 3'd6
  } cfg_idx_t;

  // Input beat kinds (in_tuser).
  typedef enum logic {
    ACT_COEF = 1'b0,
    ACT_PUSH = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_SETUP,
    ST_TAPS,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       coef_wr;
    logic       push;
    logic       setup;
    logic       tap_issue;
    logic [5:0] tap_idx;
    logic       finish;
    logic       load_out;
    logic       last;
  } srr_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       win_ok;
    logic [6:0] taps;
    logic       pipe_busy;
    logic       out_free;
  } srr_sts_t;

endpackage

FILE: rtl/core/srr_ctrl.sv
// Sequencing state machine of the resampler: walks windows, taps and outputs.
// Depends on srr_pkg; drives srr_dp through command and status structs.
module srr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_action,
  output logic              in_tready,
  input  srr_pkg::srr_sts_t sts,
  output srr_pkg::srr_cmd_t cmd
);
  import srr_pkg::*;

  state_t     state_r, state_nxt;
  logic [6:0] tap_r, tap_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       pend_r, pend_nxt;
  logic       more;

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Another output is due when its window is complete and the cap is not reached.
  assign more = sts.win_ok && (cnt_r < 7'(RESULT_CAP));

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    cmd.tap_idx = tap_r[5:0];
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_action == ACT_PUSH) begin
            cmd.push  = 1'b1;
            cnt_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = ST_WIN;
          end else begin
            cmd.coef_wr = 1'b1;
          end
        end
      end
      ST_WIN: begin
        if (pend_r) begin
          if (sts.out_free) begin
            cmd.load_out = 1'b1;
            cmd.last     = !more;
            pend_nxt     = 1'b0;
            state_nxt    = more ? ST_SETUP : ST_IDLE;
          end
        end else begin
          state_nxt = more ? ST_SETUP : ST_IDLE;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        tap_nxt   = '0;
        state_nxt = ST_TAPS;
      end
      ST_TAPS: begin
        cmd.tap_issue = 1'b1;
        if (tap_r == sts.taps - 7'd1) begin
          state_nxt = ST_DRAIN;
        end else begin
          tap_nxt = tap_r + 7'd1;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        pend_nxt   = 1'b1;
        cnt_nxt    = cnt_r + 7'd1;
        state_nxt  = ST_WIN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/srr_dp.sv
// Datapath of the resampler: registers, coefficient and history memories,
// tap pipeline, dither generator and output register. Depends on srr_pkg.
module srr_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [srr_pkg::CFG_W-1:0] cfg_wdata,
  input  logic [63:0]               in_tdata,
  input  srr_pkg::srr_cmd_t         cmd,
  output srr_pkg::srr_sts_t         sts,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,
  output logic                      out_tlast
);
  import srr_pkg::*;

  // Configuration and running state.
  logic [36:0] step_r;
  logic [31:0] mul_r, add_r;
  logic [6:0]  taps_cfg_r;
  logic [2:0]  l2p_r;
  logic [63:0] pos_r;
  logic [39:0] count_r;
  logic [31:0] ds_r, ds1_r;
  logic [HIST_AW-1:0] wp_r;

  // Per-output setup.
  logic [31:0]           lag_r;
  logic [COEF_AW-1:0]    base0_r, base1_r;
  logic [BLEND_BITS:0]   ff0_r;
  logic [BLEND_BITS-1:0] ff1_r;

  // Memories.
  logic [15:0] coef_mem [COEF_DEPTH];
  logic [31:0] hist_mem [MAX_TAPS];

  // Tap pipeline.
  logic               v1_r, v2_r, v3_r;
  logic signed [15:0] c0_r, c1_r, f_r;
  logic [31:0]        h1_r, h2_r;
  logic signed [31:0] pl_r, pr_r;
  logic signed [ACC_W-1:0] accl_r, accr_r;

  // Results.
  logic [15:0] resl_r, resr_r;
  logic        ov_r, olast_r;
  logic [31:0] odata_r;

  // Input fields.
  logic [11:0] coef_index;
  logic [15:0] coef_value, left_in, right_in;
  assign coef_index = in_tdata[11:0];
  assign coef_value = in_tdata[27:12];
  assign left_in    = in_tdata[43:28];
  assign right_in   = in_tdata[59:44];

  // Clamped tap and phase counts.
  logic [6:0] taps_eff;
  logic [2:0] b_eff;
  always_comb begin
    if (taps_cfg_r == 7'd0) begin
      taps_eff = 7'd1;
    end else if (taps_cfg_r > 7'(MAX_TAPS)) begin
      taps_eff = 7'(MAX_TAPS);
    end else begin
      taps_eff = taps_cfg_r;
    end
    b_eff = (l2p_r > 3'(MAX_LOG2_PHASES)) ? 3'(MAX_LOG2_PHASES) : l2p_r;
  end

  // Window test against the integer part of the position.
  logic [31:0] lag_w;
  assign lag_w = count_r[31:0] - pos_r[63:32];

  // Phase and blend weight from the fraction.
  logic [36:0]           frac_sh;
  logic [4:0]            fn;
  logic [BLEND_BITS-1:0] ff1;
  logic [COEF_AW-1:0]    base0;
  assign frac_sh = {5'b0, pos_r[31:0]} << b_eff;
  assign fn      = frac_sh[36:32];
  assign ff1     = frac_sh[31 -: BLEND_BITS];
  assign base0   = COEF_AW'(fn) * COEF_AW'(taps_eff);

  // Shared dither generator step.
  logic [31:0] lcg_op, lcg_res;
  logic [63:0] lcg_prod;
  assign lcg_op   = cmd.finish ? ds1_r : ds_r;
  assign lcg_prod = {32'b0, mul_r} * {32'b0, lcg_op};
  assign lcg_res  = lcg_prod[31:0] + add_r;

  // Control registers, configuration and running state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= 37'h1_0000_0000;
      mul_r      <= 32'd1103515245;
      add_r      <= 32'd12345;
      taps_cfg_r <= 7'd64;
      l2p_r      <= 3'd5;
      pos_r      <= '0;
      count_r    <= '0;
      ds_r       <= '0;
      wp_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_STEP_RATIO:  step_r     <= cfg_wdata[36:0];
          CFG_START_POS:   pos_r      <= {{25{cfg_wdata[38]}}, cfg_wdata};
          CFG_DITHER_SEED: ds_r       <= cfg_wdata[31:0];
          CFG_LCG_MUL:     mul_r      <= cfg_wdata[31:0];
          CFG_LCG_ADD:     add_r      <= cfg_wdata[31:0];
          CFG_TAPS:        taps_cfg_r <= cfg_wdata[6:0];
          CFG_LOG2_PHASES: l2p_r      <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (cmd.push) begin
        wp_r <= wp_r + HIST_AW'(1);
        if (count_r != '1) begin
          count_r <= count_r + 40'd1;
        end
      end
      if (cmd.finish) begin
        pos_r <= pos_r + {27'b0, step_r};
        ds_r  <= lcg_res;
      end
    end
  end

  // Coefficient and history writes.
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && (coef_index < COEF_AW'(COEF_DEPTH))) begin
      coef_mem[coef_index] <= coef_value;
    end
    if (cmd.push) begin
      hist_mem[wp_r] <= {right_in, left_in};
    end
  end

  // Per-output setup.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      lag_r   <= lag_w;
      base0_r <= base0;
      base1_r <= base0 + COEF_AW'(taps_eff);
      ff1_r   <= ff1;
      ff0_r   <= (BLEND_BITS+1)'(2 ** BLEND_BITS) - {1'b0, ff1};
      ds1_r   <= lcg_res;
    end
  end

  // Tap issue: age of the sample, history slot and coefficient addresses.
  logic [31:0]        age;
  logic               live;
  logic [HIST_AW-1:0] newest, slot;
  assign age    = lag_r - 32'd1 - {26'b0, cmd.tap_idx};
  assign live   = cmd.tap_issue && ({8'b0, age} < count_r);
  assign newest = wp_r - HIST_AW'(1);
  assign slot   = newest - age[HIST_AW-1:0];

  always_ff @(posedge clk) begin
    c0_r <= coef_mem[base0_r + COEF_AW'(cmd.tap_idx)];
    c1_r <= coef_mem[base1_r + COEF_AW'(cmd.tap_idx)];
    h1_r <= hist_mem[slot];
  end

  // Blend the two phases.
  logic signed [24:0] w0, w1, wsum;
  assign w0   = 25'(c0_r) * 25'($signed({1'b0, ff0_r}));
  assign w1   = 25'(c1_r) * 25'($signed({1'b0, ff1_r}));
  assign wsum = w0 + w1;

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= live;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Coefficient, products and accumulation.
  always_ff @(posedge clk) begin
    f_r  <= 16'(wsum >>> BLEND_BITS);
    h2_r <= h1_r;
    pl_r <= 32'($signed(h2_r[15:0])) * 32'(f_r);
    pr_r <= 32'($signed(h2_r[31:16])) * 32'(f_r);
    if (cmd.setup) begin
      accl_r <= '0;
      accr_r <= '0;
    end else if (v3_r) begin
      accl_r <= accl_r + {{(ACC_W-32){pl_r[31]}}, pl_r};
      accr_r <= accr_r + {{(ACC_W-32){pr_r[31]}}, pr_r};
    end
  end

  // Dither, floor shift and saturation.
  logic signed [ACC_W-1:0] suml, sumr, shl, shr;
  logic [15:0] satl, satr;
  assign suml = accl_r + $signed({{(ACC_W-15){1'b0}}, ds_r[31:17]});
  assign sumr = accr_r + $signed({{(ACC_W-15){1'b0}}, ds1_r[31:17]});
  assign shl  = suml >>> 15;
  assign shr  = sumr >>> 15;
  always_comb begin
    if (shl > $signed(ACC_W'(32767))) begin
      satl = 16'h7fff;
    end else if (shl < -$signed(ACC_W'(32768))) begin
      satl = 16'h8000;
    end else begin
      satl = shl[15:0];
    end
    if (shr > $signed(ACC_W'(32767))) begin
      satr = 16'h7fff;
    end else if (shr < -$signed(ACC_W'(32768))) begin
      satr = 16'h8000;
    end else begin
      satr = shr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      resl_r <= satl;
      resr_r <= satr;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load_out) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      odata_r <= {resr_r, resl_r};
      olast_r <= cmd.last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // Status.
  assign sts.win_ok    = !lag_w[31] && (lag_w >= {25'b0, taps_eff});
  assign sts.taps      = taps_eff;
  assign sts.pipe_busy = v1_r || v2_r || v3_r;
  assign sts.out_free  = !ov_r || out_tready;

endmodule

FILE: rtl/core/stereo_polyphase_resampler_top.sv
// Stereo 16-bit polyphase FIR resampler, top level.
// A coefficient beat is written to the coefficient memory. For each output that a sample beat
// completes, the shared tap multiply-accumulate reads one coefficient pair and one history
// entry per cycle, then a four-stage pipeline drains and the dither and saturation step runs.
// An output is set up only after the one before it has entered the output register. No input
// is taken until all outputs of a push are computed; the last of them may still wait there.
// Depends on srr_pkg, srr_ctrl and srr_dp.
module stereo_polyphase_resampler_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // coef_index, coef_value, left_in, right_in
  input  logic [0:0]                in_tuser,   // action
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,  // left_out, right_out
  output logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [srr_pkg::CFG_W-1:0] cfg_wdata
);
  import srr_pkg::*;

  srr_cmd_t cmd;
  srr_sts_t sts;

  // Sequencer.
  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  srr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: sim/tb_stereo_polyphase_resampler_top.sv
// Self-checking testbench for stereo_polyphase_resampler_top: stream driver, output monitor and
// a cycle-free predictor of the resampler that runs on every accepted input beat.
// Depends on srr_pkg and the RTL of stereo_polyphase_resampler_top.
`timescale 1ns / 1ps

module tb_stereo_polyphase_resampler_top;
  import srr_pkg::*;

  localparam int STALL_LIMIT = 6000;
  // Every setting below reads only coefficient addresses under this bound.
  localparam int COEF_FILL   = 132;

  typedef struct {
    action_t     act;
    logic [63:0] data;
  } in_beat_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } stereo_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [0:0] in_tuser = ACT_COEF;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_STEP_RATIO;
  logic [CFG_W-1:0] cfg_wdata = '0;

  stereo_polyphase_resampler_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Beats waiting to be driven and output samples waiting to arrive.
  in_beat_t    pending_beats[$];
  stereo_out_t expected_samples[$];

  // Predictor copy of the configuration.
  bit [36:0] step_r = 37'h1_0000_0000;
  bit [31:0] lcg_mul_r = 32'd1103515245;
  bit [31:0] lcg_add_r = 32'd12345;
  bit [6:0]  taps_r = 7'd64;
  bit [2:0]  log2_r = 3'd5;

  // Predictor copy of the state.
  bit [63:0] position = '0;
  bit [39:0] sample_count = '0;
  bit [31:0] dither_state = '0;
  logic signed [15:0] coef_table[COEF_DEPTH];
  bit [31:0] history[MAX_TAPS];
  int unsigned write_slot = 0;

  logic in_fire = 1'b0;
  logic no_idle = 1'b0;
  int mismatch_count = 0;
  int result_count = 0;
  int push_count = 0;
  int coef_count = 0;
  int quiet_cycles = 0;

  initial begin
    foreach (history[i]) history[i] = '0;
  end

  function automatic bit [31:0] lcg_step(bit [31:0] s);
    return lcg_mul_r * s + lcg_add_r;
  endfunction

  function automatic logic [15:0] saturate16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Pushes one stereo pair and predicts every output whose window now ends at it.
  function automatic void predict_outputs(logic [15:0] l, logic [15:0] r);
    int unsigned tp, b, fn, ff1, newest, slot, n;
    bit [31:0] hi, lo, lag, age, ds1, h;
    longint acc0, acc1, c0, c1, f;
    stereo_out_t e;
    newest = write_slot;
    history[newest] = {r, l};
    write_slot = (write_slot + 1) % MAX_TAPS;
    if (sample_count != 40'hff_ffff_ffff) sample_count++;
    tp = (taps_r == 0) ? 1 : ((taps_r > MAX_TAPS) ? MAX_TAPS : taps_r);
    b = (log2_r > MAX_LOG2_PHASES) ? MAX_LOG2_PHASES : log2_r;
    n = 0;
    while (n < RESULT_CAP) begin
      hi = position[63:32];
      lo = position[31:0];
      lag = sample_count[31:0] - hi;
      if (lag[31] || lag < tp) break;
      fn = (b == 0) ? 0 : (lo >> (32 - b));
      ff1 = (lo >> (32 - b - BLEND_BITS)) & ((1 << BLEND_BITS) - 1);
      acc0 = 0;
      acc1 = 0;
      for (int unsigned j = 0; j < tp; j++) begin
        c0 = coef_table[fn * tp + j];
        c1 = coef_table[(fn + 1) * tp + j];
        f = (c0 * longint'((1 << BLEND_BITS) - ff1) + c1 * longint'(ff1)) >>> BLEND_BITS;
        age = lag - 1 - j;
        if (64'(age) >= 64'(sample_count)) continue;
        slot = (newest + MAX_TAPS - (age % MAX_TAPS)) % MAX_TAPS;
        h = history[slot];
        acc0 += longint'($signed(h[15:0])) * f;
        acc1 += longint'($signed(h[31:16])) * f;
      end
      // Left takes the current dither word, right the one a step ahead.
      ds1 = lcg_step(dither_state);
      acc0 += longint'(dither_state >> 17);
      acc1 += longint'(ds1 >> 17);
      e.left = saturate16(acc0 >>> 15);
      e.right = saturate16(acc1 >>> 15);
      e.last = 1'b0;
      expected_samples.push_back(e);
      position += 64'(step_r);
      dither_state = lcg_step(lcg_step(dither_state));
      n++;
    end
    if (n > 0) expected_samples[expected_samples.size() - 1].last = 1'b1;
  endfunction

  // Input acceptance, output checking and the stall watchdog.
  always @(posedge clk) begin
    stereo_out_t e;
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_PUSH) begin
          push_count++;
          predict_outputs(in_tdata[43:28], in_tdata[59:44]);
        end else begin
          coef_count++;
          if (in_tdata[11:0] < COEF_DEPTH) coef_table[in_tdata[11:0]] = in_tdata[27:12];
        end
      end
      if (out_tvalid && out_tready) begin
        result_count++;
        if (expected_samples.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected output beat L=%h R=%h last=%b", $realtime,
                     out_tdata[15:0], out_tdata[31:16], out_tlast);
          mismatch_count++;
        end else begin
          e = expected_samples.pop_front();
          if (e.left !== out_tdata[15:0] || e.right !== out_tdata[31:16] ||
              e.last !== out_tlast) begin
            if (mismatch_count < 10)
              $display("%0t: output %0d expected L=%h R=%h last=%b, got L=%h R=%h last=%b",
                       $realtime, result_count, e.left, e.right, e.last,
                       out_tdata[15:0], out_tdata[31:16], out_tlast);
            mismatch_count++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_stereo_polyphase_resampler_top: done, errors");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sender: offers the next pending beat once the current one is taken.
  always @(negedge clk) begin
    in_beat_t bt;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (pending_beats.size() > 0 && (no_idle || $urandom_range(99) >= 7)) begin
        bt = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= bt.data;
        in_tuser <= bt.act;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random.
  always @(negedge clk) begin
    if (rst_n) out_tready <= no_idle || ($urandom_range(99) >= 7);
  end

  task automatic add_coef(int unsigned idx, logic [15:0] val);
    in_beat_t bt;
    bt.act = ACT_COEF;
    bt.data = {36'd0, val, idx[11:0]};
    pending_beats.push_back(bt);
  endtask

  task automatic add_push(logic [15:0] l, logic [15:0] r);
    in_beat_t bt;
    bt.act = ACT_PUSH;
    bt.data = {4'd0, r, l, 28'd0};
    pending_beats.push_back(bt);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_random(int n);
    repeat (n) begin
      if ($urandom_range(99) < 10) add_coef($urandom_range(4095), 16'($urandom));
      else add_push(rand_sample(), rand_sample());
    end
  endtask

  // Waits until every beat is taken and every output has arrived, then lets the block settle.
  task automatic drain();
    while (pending_beats.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEP_RATIO:  step_r = val[36:0];
      CFG_START_POS:   position = {{25{val[38]}}, val[38:0]};
      CFG_DITHER_SEED: dither_state = val[31:0];
      CFG_LCG_MUL:     lcg_mul_r = val[31:0];
      CFG_LCG_ADD:     lcg_add_r = val[31:0];
      CFG_TAPS:        taps_r = val[6:0];
      CFG_LOG2_PHASES: log2_r = val[2:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [63:0] step, logic [63:0] start, logic [31:0] seed,
                           logic [31:0] mul, logic [31:0] add, logic [6:0] taps,
                           logic [2:0] lp);
    write_reg(CFG_STEP_RATIO, step);
    write_reg(CFG_START_POS, start);
    write_reg(CFG_DITHER_SEED, 64'(seed));
    write_reg(CFG_LCG_MUL, 64'(mul));
    write_reg(CFG_LCG_ADD, 64'(add));
    write_reg(CFG_TAPS, 64'(taps));
    write_reg(CFG_LOG2_PHASES, 64'(lp));
  endtask

  function automatic logic [63:0] rand_step();
    return 64'h4000_0000 + ({$urandom, $urandom} % 64'h3_C000_0001);
  endfunction

  function automatic logic [63:0] rand_start();
    return {{25{1'b0}}, 7'($urandom), 32'($urandom)};
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the low part of the table; no setting below reads beyond it.
    no_idle = 1'b1;
    for (int i = 0; i < COEF_FILL; i++) add_coef(i, 16'($urandom));
    drain();
    no_idle = 1'b0;

    // Directed: coefficient extremes, ignored addresses, sample extremes.
    configure(64'h8000_0000, 64'd0, 32'd0, 32'd1103515245, 32'd12345, 7'd4, 3'd5);
    add_coef(0, 16'h8000);
    add_coef(COEF_DEPTH - 1, 16'h7fff);
    add_coef(COEF_DEPTH, 16'h1234);
    add_coef(4095, 16'hffff);
    for (int i = 1; i < 8; i++) add_coef(i, 16'h7fff);
    for (int i = 0; i < 3; i++) begin
      add_push(16'h7fff, 16'h8000);
      add_push(16'h8000, 16'h7fff);
      add_push(16'h7fff, 16'h7fff);
      add_push(16'h8000, 16'h8000);
    end
    add_push(16'h0000, 16'hffff);
    add_push(16'hffff, 16'h0000);
    drain();

    // Unit step with the full tap count, with no idling on either side.
    no_idle = 1'b1;
    configure(64'h1_0000_0000, 64'd0, 32'd0, 32'd1103515245, 32'd12345, 7'd64, 3'd0);
    add_random(40);
    drain();
    no_idle = 1'b0;

    // Smallest step, most negative start: pushes hit the per-push output cap.
    configure(64'h400_0000, 64'h40_0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              7'd4, 3'd0);
    add_random(30);
    drain();

    // Largest step and start, tap count above the maximum.
    configure(64'h10_0000_0000, 64'h3f_ffff_ffff, 32'd0, 32'd0, 32'd0, 7'd127, 3'd0);
    add_random(40);
    drain();

    // Zero tap count and a phase count above the maximum.
    configure(rand_step(), rand_start(), $urandom, $urandom, $urandom, 7'd0, 3'd6);
    add_random(40);
    drain();

    // Random settings; the sender holds off midway until every output is back.
    configure(rand_step(), rand_start(), $urandom, $urandom, $urandom,
              7'($urandom_range(4, 1)), 3'($urandom_range(7)));
    add_random(25);
    drain();
    add_random(25);
    drain();

    configure(rand_step(), rand_start(), $urandom, $urandom, $urandom,
              7'($urandom_range(64, 1)), 3'd0);
    add_random(40);
    drain();

    configure(64'h2_0000_0000, rand_start(), $urandom, 32'd1103515245, 32'd12345,
              7'd14, 3'd3);
    add_random(40);
    drain();
    repeat (200) @(posedge clk);

    mismatch_count += expected_samples.size();
    $display("Covered %0d sample pushes and %0d coefficient loads over eight settings,",
             push_count, coef_count);
    $display("checking %0d output pairs; %0d mismatches.", result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_stereo_polyphase_resampler_top: done, clean");
    end else begin
      $display("tb_stereo_polyphase_resampler_top: done, errors");
    end
    $finish;
  end

endmodule
